FILE: hdl/wmma_pkg.sv
// Shared types and constants for the weight matrix motif alignment unit.
package wmma_pkg;

    localparam int W_BITS      = 16;
    localparam int NBASE       = 4;
    localparam int ROW_W       = NBASE * W_BITS;
    localparam int THR_BITS    = 15;
    localparam int SIM_BITS    = 16;
    localparam int SIM_ONE     = 32768;
    localparam int OVERHANG    = 2;
    localparam int MIN_OVERLAP = 6;
    localparam int BREAK_ROWS  = 4;
    localparam int NORM_BITS   = 31;
    localparam int FRAC_BITS   = 15;
    localparam int DIV_STEPS   = NORM_BITS + FRAC_BITS;

    localparam logic [THR_BITS-1:0] THR_RESET = 15'd22938;

    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_CMP    = 2'd2,
        MODE_CLR    = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic signed [W_BITS-1:0]  weight_a;
        logic signed [W_BITS-1:0]  weight_c;
        logic signed [W_BITS-1:0]  weight_g;
        logic signed [W_BITS-1:0]  weight_t;
    } t_in_item;

    typedef struct packed {
        logic [SIM_BITS-1:0] similarity;
        logic signed [7:0]   best_offset;
        logic                reverse_strand;
        logic [6:0]          overlap_rows;
        logic                above_threshold;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctl;

endpackage

FILE: hdl/weight_matrix_motif_alignment_unit.sv
// Top level of the weight matrix motif alignment unit.
// Load items (modes 0 and 1) append one row to a motif; neither they nor clear (mode 3)
// yields a result. A compare item keeps the input stalled while it scans both strands:
// per strand it sets up the offset range and walks |n1-n2|+4 offsets; each offset runs
// its bookkeeping states and, for each overlapping row, motif RAM read, four base lanes,
// merge and early-exit check; an offset that qualifies then passes through the shared
// correlation unit (normalizing, square root, 46 divide steps) and, unless the result
// is zero, the selection states. Picking the strand reuses the selection states.
// The result waits in an output register; the next item is taken once it is stored.
// The motif stores are two MAX_ROWS x 64-bit RAMs with no clearing pass after reset.
module weight_matrix_motif_alignment_unit #(
    parameter int MAX_ROWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wmma_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wmma_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [wmma_pkg::THR_BITS-1:0] i_cfg_wdata
);
    import wmma_pkg::*;

    localparam int AW    = $clog2(MAX_ROWS);
    localparam int LW    = $clog2(MAX_ROWS + 1);
    localparam int OW    = LW + 2;
    localparam int ACC_W = 2 * W_BITS + 3 + AW;
    localparam int SC_W  = LW + 18;
    localparam int PW    = SC_W + LW + 1;

    localparam logic signed [OW-1:0]   OFF_TWO = OW'(OVERHANG);
    localparam logic signed [SC_W-1:0] SC_ONE  = SC_W'(SIM_ONE);
    localparam logic signed [SC_W-1:0] SC_SIX  = SC_W'(MIN_OVERLAP);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_START = 13'b0000000000010,
        S_OFF   = 13'b0000000000100,
        S_ROW   = 13'b0000000001000,
        S_MUL   = 13'b0000000010000,
        S_ACC   = 13'b0000000100000,
        S_CHK   = 13'b0000001000000,
        S_EVAL  = 13'b0000010000000,
        S_CORR  = 13'b0000100000000,
        S_SC1   = 13'b0001000000000,
        S_SC2   = 13'b0010000000000,
        S_NEXT  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [THR_BITS-1:0]     r_thr;
    logic [LW-1:0]           r_len1;
    logic [LW-1:0]           r_len2;
    logic                    r_rev;
    logic                    r_fin;
    logic                    r_pick;
    logic signed [OW-1:0]    r_off;
    logic signed [OW-1:0]    r_oend;
    logic [LW-1:0]           r_i;
    logic [LW-1:0]           r_j;
    logic [LW-1:0]           r_n;
    logic [SIM_BITS-1:0]     r_br;
    logic signed [OW-1:0]    r_boff;
    logic [LW-1:0]           r_bn;
    logic [SIM_BITS-1:0]     r_fr;
    logic signed [OW-1:0]    r_foff;
    logic [LW-1:0]           r_fn;
    logic signed [SC_W-1:0]  r_numa;
    logic signed [SC_W-1:0]  r_numb;
    logic                    r_out_valid;
    logic                    n_out_valid;
    t_out_item               r_out;

    logic                    in_acc;
    logic                    out_free;
    logic                    row_ok;
    logic                    we1;
    logic                    we2;
    logic [ROW_W-1:0]        wrow;
    logic [ROW_W-1:0]        q1;
    logic [ROW_W-1:0]        q2;
    logic [AW-1:0]           raddr2;
    logic [LW-1:0]           rrow2;
    logic signed [OW-1:0]    s1;
    logic signed [OW-1:0]    s2;
    logic signed [OW-1:0]    first_i;
    logic signed [OW-1:0]    off_nx;
    t_acc_ctl                acc_ctl;
    logic signed [2*W_BITS-1:0] l_pxy [NBASE];
    logic signed [2*W_BITS-1:0] l_pxx [NBASE];
    logic signed [2*W_BITS-1:0] l_pyy [NBASE];
    logic signed [ACC_W-1:0] m_sxy;
    logic signed [ACC_W-1:0] m_sxx;
    logic signed [ACC_W-1:0] m_syy;
    logic                    corr_done;
    logic                    corr_zero;
    logic [SIM_BITS-1:0]     corr_r;
    logic [SIM_BITS-1:0]     a_r;
    logic [LW-1:0]           a_n;
    logic [SIM_BITS-1:0]     b_r;
    logic [LW-1:0]           b_n;
    logic signed [SC_W-1:0]  a_rs;
    logic signed [SC_W-1:0]  a_ns;
    logic signed [SC_W-1:0]  b_rs;
    logic signed [SC_W-1:0]  b_ns;
    logic signed [PW-1:0]    lhs;
    logic signed [PW-1:0]    rhs;
    logic                    score_gt;
    logic                    better;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign row_ok   = (r_i < r_len1) && (r_j < r_len2);
    assign s1       = $signed({2'b00, r_len1});
    assign s2       = $signed({2'b00, r_len2});
    assign first_i  = (r_off > 0) ? r_off : '0;
    assign off_nx   = r_off + OW'(1);

    assign wrow = {i_in_item.weight_t, i_in_item.weight_g,
                   i_in_item.weight_c, i_in_item.weight_a};
    assign we1  = in_acc && (i_in_item.mode == MODE_LOAD_A) && (r_len1 < LW'(MAX_ROWS));
    assign we2  = in_acc && (i_in_item.mode == MODE_LOAD_B) && (r_len2 < LW'(MAX_ROWS));

    assign rrow2  = r_rev ? (r_len2 - LW'(1) - r_j) : r_j;
    assign raddr2 = rrow2[AW-1:0];

    wmma_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_len1[AW-1:0]),
        .i_wdata (wrow),
        .i_re    (r_state == S_ROW),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (q1)
    );

    wmma_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_len2[AW-1:0]),
        .i_wdata (wrow),
        .i_re    (r_state == S_ROW),
        .i_raddr (raddr2),
        .o_rdata (q2)
    );

    for (genvar m = 0; m < NBASE; m++) begin : g_lane
        logic signed [W_BITS-1:0] lx;
        logic signed [W_BITS-1:0] ly;
        assign lx = q1[m*W_BITS +: W_BITS];
        assign ly = r_rev ? q2[(NBASE-1-m)*W_BITS +: W_BITS] : q2[m*W_BITS +: W_BITS];
        wmma_lane u_lane (
            .i_clk (i_clk),
            .i_en  (r_state == S_MUL),
            .i_x   (lx),
            .i_y   (ly),
            .o_pxy (l_pxy[m]),
            .o_pxx (l_pxx[m]),
            .o_pyy (l_pyy[m])
        );
    end

    assign acc_ctl.clear = (r_state == S_OFF);
    assign acc_ctl.add   = (r_state == S_ACC);

    wmma_merge #(.ACC_W(ACC_W)) u_merge (
        .i_clk (i_clk),
        .i_ctl (acc_ctl),
        .i_pxy (l_pxy),
        .i_pxx (l_pxx),
        .i_pyy (l_pyy),
        .o_sxy (m_sxy),
        .o_sxx (m_sxx),
        .o_syy (m_syy)
    );

    wmma_corr #(.ACC_W(ACC_W)) u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_EVAL && n_state == S_CORR),
        .i_sxy   ($unsigned(m_sxy)),
        .i_sxx   ($unsigned(m_sxx)),
        .i_syy   ($unsigned(m_syy)),
        .o_done  (corr_done),
        .o_zero  (corr_zero),
        .o_r     (corr_r)
    );

    assign a_r  = r_fin ? r_br : corr_r;
    assign a_n  = r_fin ? r_bn : r_n;
    assign b_r  = r_fin ? r_fr : r_br;
    assign b_n  = r_fin ? r_fn : r_bn;
    assign a_rs = $signed({{(SC_W-SIM_BITS){1'b0}}, a_r});
    assign a_ns = $signed({{(SC_W-LW){1'b0}}, a_n});
    assign b_rs = $signed({{(SC_W-SIM_BITS){1'b0}}, b_r});
    assign b_ns = $signed({{(SC_W-LW){1'b0}}, b_n});
    assign lhs  = PW'(r_numa) * PW'(b_ns);
    assign rhs  = PW'(r_numb) * PW'(a_ns);

    always_comb begin
        if (a_n == '0) begin
            score_gt = 1'b0;
        end else if (b_n == '0) begin
            score_gt = 1'b1;
        end else begin
            score_gt = lhs > rhs;
        end
        better = ((b_r < {1'b0, r_thr}) && (a_r > b_r))
              || ((a_r > {1'b0, r_thr}) && score_gt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_in_item.mode == MODE_CMP) n_state = S_START;
            S_START: n_state = S_OFF;
            S_OFF:   n_state = S_ROW;
            S_ROW:   n_state = row_ok ? S_MUL : S_EVAL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_CHK;
            S_CHK: begin
                if (m_sxy < 0 && r_n >= LW'(BREAK_ROWS)) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_EVAL: begin
                if (m_sxy < 0 || r_n < LW'(MIN_OVERLAP)) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_CORR;
                end
            end
            S_CORR:  if (corr_done) n_state = corr_zero ? S_NEXT : S_SC1;
            S_SC1:   n_state = S_SC2;
            S_SC2:   n_state = r_fin ? S_OUT : S_NEXT;
            S_NEXT: begin
                if (off_nx < r_oend) begin
                    n_state = S_OFF;
                end else begin
                    n_state = r_rev ? S_SC1 : S_START;
                end
            end
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == S_OUT && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_len1      <= '0;
            r_len2      <= '0;
            r_rev       <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (we1) begin
                r_len1 <= r_len1 + LW'(1);
            end
            if (we2) begin
                r_len2 <= r_len2 + LW'(1);
            end
            if (in_acc && i_in_item.mode == MODE_CLR) begin
                r_len1 <= '0;
                r_len2 <= '0;
            end
            case (r_state)
                S_START: begin
                    if (s2 > s1) begin
                        r_off  <= s1 - OFF_TWO - s2;
                        r_oend <= OFF_TWO;
                    end else begin
                        r_off  <= -OFF_TWO;
                        r_oend <= s1 - s2 + OFF_TWO;
                    end
                    r_br   <= '0;
                    r_boff <= '0;
                    r_bn   <= '0;
                end
                S_OFF: begin
                    r_i <= first_i[LW-1:0];
                    r_j <= LW'(first_i - r_off);
                    r_n <= '0;
                end
                S_ACC: begin
                    r_n <= r_n + LW'(1);
                end
                S_CHK: begin
                    r_i <= r_i + LW'(1);
                    r_j <= r_j + LW'(1);
                end
                S_SC1: begin
                    r_numa <= SC_W'(((a_ns * a_rs) <<< 1) + (SC_ONE - a_rs) * (a_ns - SC_SIX));
                    r_numb <= SC_W'(((b_ns * b_rs) <<< 1) + (SC_ONE - b_rs) * (b_ns - SC_SIX));
                end
                S_SC2: begin
                    if (r_fin) begin
                        r_pick <= better;
                    end else if (better) begin
                        r_br   <= corr_r;
                        r_boff <= r_off;
                        r_bn   <= r_n;
                    end
                end
                S_NEXT: begin
                    r_off <= off_nx;
                    if (!(off_nx < r_oend)) begin
                        if (r_rev) begin
                            r_fin <= 1'b1;
                        end else begin
                            r_fr   <= r_br;
                            r_foff <= r_boff;
                            r_fn   <= r_bn;
                            r_rev  <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.similarity      <= r_pick ? r_br : r_fr;
                        r_out.best_offset     <= 8'(r_pick ? r_boff : r_foff);
                        r_out.reverse_strand  <= r_pick;
                        r_out.overlap_rows    <= 7'(r_pick ? r_bn : r_fn);
                        r_out.above_threshold <= (r_pick ? r_br : r_fr) >= {1'b0, r_thr};
                        r_rev <= 1'b0;
                        r_fin <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: hdl/wmma_ram.sv
// Generic simple dual-port RAM with registered read.
module wmma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: hdl/wmma_lane.sv
// One base lane: registered cross and square products of a weight pair.
module wmma_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [wmma_pkg::W_BITS-1:0]   i_x,
    input  logic signed [wmma_pkg::W_BITS-1:0]   i_y,
    output logic signed [2*wmma_pkg::W_BITS-1:0] o_pxy,
    output logic signed [2*wmma_pkg::W_BITS-1:0] o_pxx,
    output logic signed [2*wmma_pkg::W_BITS-1:0] o_pyy
);
    import wmma_pkg::*;

    logic signed [2*W_BITS-1:0] r_pxy;
    logic signed [2*W_BITS-1:0] r_pxx;
    logic signed [2*W_BITS-1:0] r_pyy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxy <= i_x * i_y;
            r_pxx <= i_x * i_x;
            r_pyy <= i_y * i_y;
        end
    end

    assign o_pxy = r_pxy;
    assign o_pxx = r_pxx;
    assign o_pyy = r_pyy;

endmodule

FILE: hdl/wmma_merge.sv
// Merge of the base lanes into the three running sums of one offset.
module wmma_merge #(
    parameter int ACC_W = 41
) (
    input  logic                              i_clk,
    input  wmma_pkg::t_acc_ctl                i_ctl,
    input  logic signed [2*wmma_pkg::W_BITS-1:0] i_pxy [wmma_pkg::NBASE],
    input  logic signed [2*wmma_pkg::W_BITS-1:0] i_pxx [wmma_pkg::NBASE],
    input  logic signed [2*wmma_pkg::W_BITS-1:0] i_pyy [wmma_pkg::NBASE],
    output logic signed [ACC_W-1:0]           o_sxy,
    output logic signed [ACC_W-1:0]           o_sxx,
    output logic signed [ACC_W-1:0]           o_syy
);
    import wmma_pkg::*;

    logic signed [ACC_W-1:0] s_xy;
    logic signed [ACC_W-1:0] s_xx;
    logic signed [ACC_W-1:0] s_yy;
    logic signed [ACC_W-1:0] r_sxy;
    logic signed [ACC_W-1:0] r_sxx;
    logic signed [ACC_W-1:0] r_syy;

    always_comb begin
        s_xy = '0;
        s_xx = '0;
        s_yy = '0;
        for (int k = 0; k < NBASE; k++) begin
            s_xy = s_xy + ACC_W'(i_pxy[k]);
            s_xx = s_xx + ACC_W'(i_pxx[k]);
            s_yy = s_yy + ACC_W'(i_pyy[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
        end else if (i_ctl.add) begin
            r_sxy <= r_sxy + s_xy;
            r_sxx <= r_sxx + s_xx;
            r_syy <= r_syy + s_yy;
        end
    end

    assign o_sxy = r_sxy;
    assign o_sxx = r_sxx;
    assign o_syy = r_syy;

endmodule

FILE: hdl/wmma_corr.sv
// Correlation unit: normalize, multiply, bit-pair square root, long division.
module wmma_corr #(
    parameter int ACC_W = 41
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ACC_W-1:0]              i_sxy,
    input  logic [ACC_W-1:0]              i_sxx,
    input  logic [ACC_W-1:0]              i_syy,
    output logic                          o_done,
    output logic                          o_zero,
    output logic [wmma_pkg::SIM_BITS-1:0] o_r
);
    import wmma_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_NORM = 6'b000010,
        C_MUL  = 6'b000100,
        C_SQRT = 6'b001000,
        C_DIV  = 6'b010000,
        C_DONE = 6'b100000
    } t_cstate;

    t_cstate                r_state;
    logic [ACC_W-1:0]       r_ux;
    logic [ACC_W-1:0]       r_uy;
    logic [ACC_W-1:0]       r_uxy;
    logic [63:0]            r_v;
    logic [63:0]            r_res;
    logic [63:0]            r_bit;
    logic [31:0]            r_den;
    logic [31:0]            r_rem;
    logic [DIV_STEPS-1:0]   r_num;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_zero;
    logic [32:0]            div_t;
    logic                   div_ge;
    logic [63:0]            sq_t;

    assign div_t  = {r_rem, r_num[DIV_STEPS-1]};
    assign div_ge = div_t >= {1'b0, r_den};
    assign sq_t   = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_zero  <= 1'b0;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_ux    <= i_sxx;
                        r_uy    <= i_syy;
                        r_uxy   <= i_sxy;
                        r_zero  <= 1'b0;
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (|r_ux[ACC_W-1:NORM_BITS]) begin
                        r_ux  <= r_ux >> 2;
                        r_uxy <= r_uxy >> 1;
                    end else if (|r_uy[ACC_W-1:NORM_BITS]) begin
                        r_uy  <= r_uy >> 2;
                        r_uxy <= r_uxy >> 1;
                    end else begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_v     <= {33'b0, r_ux[NORM_BITS-1:0]} * {33'b0, r_uy[NORM_BITS-1:0]};
                    r_res   <= '0;
                    r_bit   <= 64'h4000_0000_0000_0000;
                    r_state <= C_SQRT;
                end
                C_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_v >= sq_t) begin
                            r_v   <= r_v - sq_t;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else if (r_res == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= C_DONE;
                    end else begin
                        r_den   <= r_res[31:0];
                        r_num   <= {r_uxy[NORM_BITS-1:0], {FRAC_BITS{1'b0}}};
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    r_rem <= div_ge ? 32'(div_t - {1'b0, r_den}) : div_t[31:0];
                    r_num <= {r_num[DIV_STEPS-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= C_DONE;
                    end
                end
                C_DONE: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == C_DONE);
    assign o_zero = r_zero;
    assign o_r    = (r_num > DIV_STEPS'(SIM_ONE)) ? SIM_BITS'(SIM_ONE) : r_num[SIM_BITS-1:0];

endmodule

FILE: hdl/wmma_chk.sv
// Port-level checker for the motif alignment unit, bound to the top level.
module wmma_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input wmma_pkg::t_in_item            i_in_item,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input wmma_pkg::t_out_item           o_out_item,
    input logic                          i_cfg_we,
    input logic [wmma_pkg::THR_BITS-1:0] i_cfg_wdata
);
    import wmma_pkg::*;

    logic [THR_BITS-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.similarity <= SIM_BITS'(SIM_ONE))
        else $error("similarity above one");

    a_thr_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.above_threshold ==
            (o_out_item.similarity >= {1'b0, r_thr}))
        else $error("threshold flag disagrees with similarity");

    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overlap_rows == '0 |->
            o_out_item.similarity == '0 && o_out_item.best_offset == '0
            && !o_out_item.reverse_strand)
        else $error("empty match carries data");

endmodule

bind weight_matrix_motif_alignment_unit wmma_chk u_wmma_chk (.*);
